// ===== rtl/wsdf_pkg.sv =====
`timescale 1ns / 1ps

package wsdf_pkg;

  // Result kinds
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_EMPTY   = 2'd1;
  localparam logic [1:0] KIND_CLOSE   = 2'd2;

  // Opcodes of interest
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;

  // Seven-bit length codes that announce an extended length
  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;

  // Extended length bytes still due minus one
  localparam logic [2:0] EXT16_BYTES_M1 = 3'd1;
  localparam logic [2:0] EXT64_BYTES_M1 = 3'd7;

  localparam logic [1:0] KEY_LAST = 2'd3;

endpackage

// ===== rtl/wsdf_rx_if.sv =====
`timescale 1ns / 1ps

interface wsdf_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/wsdf_res_if.sv =====
`timescale 1ns / 1ps

interface wsdf_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] payload_byte;
  logic [3:0] frame_opcode;
  logic       last;

  modport source (output valid, output kind, output payload_byte, output frame_opcode,
                  output last, input ready);
  modport sink (input valid, input kind, input payload_byte, input frame_opcode,
                input last, output ready);
endinterface

// ===== rtl/websocket_frame_deframer.sv =====
`timescale 1ns / 1ps

// Channel  Dir  Payload                                    Beat
// rx       in   rx_byte[7:0]                               one stream byte
// res      out  kind[1:0] payload_byte[7:0]                at most one per rx beat
//               frame_opcode[3:0] last
//
// One byte a cycle while res does not stall: a beat is captured in the input
// register, parsed there once the result slot is free or draining, and its
// result, if any, lands in the result register.
// Reset clears the parser to expect the first header byte; after a close
// frame every byte is dropped until reset.
// A stalled res holds its beat; rx still takes one more beat into an empty
// input register before it stalls too.

module websocket_frame_deframer
  import wsdf_pkg::*;
#(
  parameter int LEN_BITS = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  wsdf_rx_if.sink    rx,
  wsdf_res_if.source res
);

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_EXT,
    PH_KEY,
    PH_PAY,
    PH_CLOSED
  } phase_e;

  phase_e              phase_q, phase_d;
  logic [3:0]          opcode_q, opcode_d;
  logic                mask_on_q, mask_on_d;
  logic [LEN_BITS-1:0] rem_q, rem_d;
  logic [31:0]         key_q, key_d;
  logic [1:0]          key_idx_q, key_idx_d;
  logic [2:0]          ext_cnt_q, ext_cnt_d;

  logic                in_valid_q;
  logic [7:0]          in_byte_q;

  logic                res_valid_q;
  logic [1:0]          res_kind_q;
  logic [7:0]          res_byte_q;
  logic [3:0]          res_opcode_q;
  logic                res_last_q;

  logic                adv;
  logic                gen;
  logic [1:0]          gen_kind;
  logic [7:0]          gen_byte;
  logic                gen_last;
  logic                hdr_done;
  logic [LEN_BITS-1:0] hdr_len;
  logic [6:0]          len7;
  logic [7:0]          key_byte;
  logic [LEN_BITS-1:0] rem_dec;
  logic                is_data;

  // Parse when a byte is held and the result slot is free or draining
  assign adv      = in_valid_q && (!res_valid_q || res.ready);
  assign rx.ready = !in_valid_q || adv;

  assign len7    = in_byte_q[6:0];
  assign is_data = (opcode_q == OP_TEXT) || (opcode_q == OP_BINARY);
  assign rem_dec = rem_q - LEN_BITS'(rem_q != '0);

  always_comb begin
    case (key_idx_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  always_comb begin
    phase_d   = phase_q;
    opcode_d  = opcode_q;
    mask_on_d = mask_on_q;
    rem_d     = rem_q;
    key_d     = key_q;
    key_idx_d = key_idx_q;
    ext_cnt_d = ext_cnt_q;
    gen       = 1'b0;
    gen_kind  = KIND_PAYLOAD;
    gen_byte  = 8'h00;
    gen_last  = 1'b1;
    hdr_done  = 1'b0;
    hdr_len   = rem_q;

    unique case (phase_q)
      PH_HDR0: begin
        opcode_d = in_byte_q[3:0];
        phase_d  = PH_HDR1;
      end
      PH_HDR1: begin
        mask_on_d = in_byte_q[7];
        key_d     = '0;
        key_idx_d = '0;
        rem_d     = '0;
        if (len7 == LEN7_EXT16) begin
          ext_cnt_d = EXT16_BYTES_M1;
          phase_d   = PH_EXT;
        end else if (len7 == LEN7_EXT64) begin
          ext_cnt_d = EXT64_BYTES_M1;
          phase_d   = PH_EXT;
        end else begin
          rem_d = {{(LEN_BITS-7){1'b0}}, len7};
          if (in_byte_q[7]) begin
            phase_d = PH_KEY;
          end else begin
            hdr_done = 1'b1;
            hdr_len  = rem_d;
          end
        end
      end
      PH_EXT: begin
        // Saturate a length that overflows the counter
        if (|rem_q[LEN_BITS-1 -: 8]) begin
          rem_d = '1;
        end else begin
          rem_d = {rem_q[LEN_BITS-9:0], in_byte_q};
        end
        if (ext_cnt_q != '0) begin
          ext_cnt_d = ext_cnt_q - 3'd1;
        end else if (mask_on_q) begin
          key_idx_d = '0;
          phase_d   = PH_KEY;
        end else begin
          hdr_done = 1'b1;
          hdr_len  = rem_d;
        end
      end
      PH_KEY: begin
        key_d = {key_q[23:0], in_byte_q};
        if (key_idx_q != KEY_LAST) begin
          key_idx_d = key_idx_q + 2'd1;
        end else begin
          hdr_done = 1'b1;
        end
      end
      PH_PAY: begin
        key_idx_d = key_idx_q + 2'd1;
        rem_d     = rem_dec;
        gen_last  = (rem_dec == '0);
        gen_byte  = mask_on_q ? (in_byte_q ^ key_byte) : in_byte_q;
        if (gen_last) phase_d = PH_HDR0;
        if (is_data) begin
          gen = 1'b1;
        end else if (opcode_q == OP_CLOSE && gen_last) begin
          phase_d  = PH_CLOSED;
          gen      = 1'b1;
          gen_kind = KIND_CLOSE;
          gen_byte = 8'h00;
        end
      end
      PH_CLOSED: ;
      default: phase_d = PH_HDR0;
    endcase

    // Header complete: start the payload or finish an empty frame
    if (hdr_done) begin
      key_idx_d = '0;
      if (hdr_len != '0) begin
        phase_d = PH_PAY;
      end else if (opcode_q == OP_CLOSE) begin
        phase_d  = PH_CLOSED;
        gen      = 1'b1;
        gen_kind = KIND_CLOSE;
      end else begin
        phase_d = PH_HDR0;
        if (is_data) begin
          gen      = 1'b1;
          gen_kind = KIND_EMPTY;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HDR0;
      opcode_q    <= '0;
      mask_on_q   <= 1'b0;
      rem_q       <= '0;
      key_q       <= '0;
      key_idx_q   <= '0;
      ext_cnt_q   <= '0;
      in_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (rx.ready) in_valid_q <= rx.valid;
      if (adv) begin
        phase_q   <= phase_d;
        opcode_q  <= opcode_d;
        mask_on_q <= mask_on_d;
        rem_q     <= rem_d;
        key_q     <= key_d;
        key_idx_q <= key_idx_d;
        ext_cnt_q <= ext_cnt_d;
        res_valid_q <= gen;
      end else if (res.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx.ready && rx.valid) in_byte_q <= rx.rx_byte;
    if (adv && gen) begin
      res_kind_q   <= gen_kind;
      res_byte_q   <= gen_byte;
      res_opcode_q <= opcode_q;
      res_last_q   <= gen_last;
    end
  end

  assign res.valid        = res_valid_q;
  assign res.kind         = res_kind_q;
  assign res.payload_byte = res_byte_q;
  assign res.frame_opcode = res_opcode_q;
  assign res.last         = res_last_q;

endmodule

// ===== bench/websocket_frame_deframer_tb.sv =====
`timescale 1ns / 1ps

module websocket_frame_deframer_tb;
  import wsdf_pkg::*;

  localparam int LEN_BITS = 64;
  localparam logic [63:0] LEN_ALL = {64{1'b1}} >> (64 - LEN_BITS);
  localparam int LIMIT_CYCLES = 200000;
  localparam int STALL_CYCLES = 300;
  localparam int RANDOM_BYTES = 750;
  localparam int DIRECTED_ROWS = 26;

  localparam logic [3:0] OP_CONT = 4'h0;
  localparam logic [3:0] OP_PING = 4'h9;
  localparam logic [3:0] OP_PONG = 4'hA;

  typedef enum logic [2:0] {
    PS_HDR0, PS_HDR1, PS_EXT, PS_KEY, PS_PAY, PS_CLOSED
  } parse_phase_e;

  typedef enum logic [1:0] {
    CHK_MODEL, CHK_NONE, CHK_TYPED
  } chk_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [3:0] opcode;
    logic       last;
  } deframe_res_t;

  typedef struct packed {
    logic [7:0]   b;
    chk_e         chk;
    deframe_res_t res;
  } rx_row_t;

  localparam deframe_res_t NO_RES = '0;

  // Header bytes expect nothing; empty messages and the masked extremes are typed in.
  localparam rx_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{8'h81, CHK_NONE,  NO_RES},
    '{8'h00, CHK_TYPED, '{KIND_EMPTY, 8'h00, OP_TEXT, 1'b1}},
    '{8'h72, CHK_NONE,  NO_RES},
    '{8'h80, CHK_NONE,  NO_RES},
    '{8'hFF, CHK_NONE,  NO_RES},
    '{8'h00, CHK_NONE,  NO_RES},
    '{8'hA5, CHK_NONE,  NO_RES},
    '{8'h5A, CHK_TYPED, '{KIND_EMPTY, 8'h00, OP_BINARY, 1'b1}},
    '{8'h89, CHK_NONE,  NO_RES},
    '{8'h01, CHK_NONE,  NO_RES},
    '{8'h33, CHK_NONE,  NO_RES},
    '{8'h82, CHK_NONE,  NO_RES},
    '{8'h7E, CHK_NONE,  NO_RES},
    '{8'h00, CHK_NONE,  NO_RES},
    '{8'h00, CHK_TYPED, '{KIND_EMPTY, 8'h00, OP_BINARY, 1'b1}},
    '{8'h81, CHK_NONE,  NO_RES},
    '{8'h82, CHK_NONE,  NO_RES},
    '{8'hFF, CHK_NONE,  NO_RES},
    '{8'h0F, CHK_NONE,  NO_RES},
    '{8'h00, CHK_NONE,  NO_RES},
    '{8'h00, CHK_NONE,  NO_RES},
    '{8'h00, CHK_TYPED, '{KIND_PAYLOAD, 8'hFF, OP_TEXT, 1'b0}},
    '{8'hFF, CHK_TYPED, '{KIND_PAYLOAD, 8'hF0, OP_TEXT, 1'b1}},
    '{8'h0F, CHK_NONE,  NO_RES},
    '{8'h01, CHK_NONE,  NO_RES},
    '{8'h00, CHK_MODEL, NO_RES}
  };

  logic clk_i;
  logic rst_ni;

  wsdf_rx_if  rx ();
  wsdf_res_if res ();

  websocket_frame_deframer #(.LEN_BITS(LEN_BITS)) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .rx    (rx.sink),
    .res   (res.source)
  );

  // Parser copy
  parse_phase_e p_phase;
  logic [3:0]   p_opcode;
  logic         p_masked;
  logic [63:0]  p_remaining;
  logic [31:0]  p_key;
  logic [1:0]   p_key_idx;
  logic [2:0]   p_ext_left;

  rx_row_t      stim_q [$];
  rx_row_t      cur_row;
  deframe_res_t pending_res_q [$];
  int           rx_accepted;
  int           rx_total;
  int           err_cnt;
  int           src_idle_pct;
  int           sink_idle_pct;
  bit           stall_req;
  bit           stall_done;
  int           stall_left;
  int           cycles;

  function automatic bit finish_header(output deframe_res_t r);
    r = NO_RES;
    p_key_idx = '0;
    if (p_remaining != 0) begin
      p_phase = PS_PAY;
      return 1'b0;
    end
    if (p_opcode == OP_CLOSE) begin
      p_phase = PS_CLOSED;
      r = '{KIND_CLOSE, 8'h00, p_opcode, 1'b1};
      return 1'b1;
    end
    p_phase = PS_HDR0;
    if (p_opcode == OP_TEXT || p_opcode == OP_BINARY) begin
      r = '{KIND_EMPTY, 8'h00, p_opcode, 1'b1};
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit deframe_byte(input logic [7:0] b, output deframe_res_t r);
    logic [7:0] data;
    logic       last;
    bit         got;
    got = 1'b0;
    r = NO_RES;
    case (p_phase)
      PS_HDR0: begin
        p_opcode = b[3:0];
        p_phase = PS_HDR1;
      end
      PS_HDR1: begin
        p_masked = b[7];
        p_key = '0;
        p_key_idx = '0;
        p_remaining = '0;
        if (b[6:0] == LEN7_EXT16) begin
          p_ext_left = EXT16_BYTES_M1;
          p_phase = PS_EXT;
        end else if (b[6:0] == LEN7_EXT64) begin
          p_ext_left = EXT64_BYTES_M1;
          p_phase = PS_EXT;
        end else begin
          p_remaining = {57'd0, b[6:0]};
          if (p_masked) p_phase = PS_KEY;
          else got = finish_header(r);
        end
      end
      PS_EXT: begin
        // saturate once another byte would overflow the length register
        if (p_remaining > (LEN_ALL >> 8)) p_remaining = LEN_ALL;
        else p_remaining = ((p_remaining << 8) | {56'd0, b}) & LEN_ALL;
        if (p_ext_left != 0) begin
          p_ext_left = p_ext_left - 3'd1;
        end else if (p_masked) begin
          p_key_idx = '0;
          p_phase = PS_KEY;
        end else begin
          got = finish_header(r);
        end
      end
      PS_KEY: begin
        p_key = {p_key[23:0], b};
        if (p_key_idx != KEY_LAST) p_key_idx = p_key_idx + 2'd1;
        else got = finish_header(r);
      end
      PS_PAY: begin
        data = p_masked ? (b ^ p_key[8 * (3 - p_key_idx) +: 8]) : b;
        p_key_idx = p_key_idx + 2'd1;
        if (p_remaining != 0) p_remaining = p_remaining - 64'd1;
        last = (p_remaining == 0);
        if (last) p_phase = PS_HDR0;
        if (p_opcode == OP_TEXT || p_opcode == OP_BINARY) begin
          r = '{KIND_PAYLOAD, data, p_opcode, last};
          got = 1'b1;
        end else if (p_opcode == OP_CLOSE && last) begin
          p_phase = PS_CLOSED;
          r = '{KIND_CLOSE, 8'h00, p_opcode, 1'b1};
          got = 1'b1;
        end
      end
      default: ;
    endcase
    return got;
  endfunction

  task automatic push_byte(input logic [7:0] b);
    stim_q.insert(stim_q.size(), '{b, CHK_MODEL, NO_RES});
  endtask

  // One frame of random content; noisy frames carry any opcode but close and any flag bits.
  task automatic add_frame(input bit noisy);
    logic [3:0]  op;
    logic        m;
    logic [63:0] len;
    int          sel;
    sel = $urandom_range(0, 9);
    if (noisy) begin
      op = 4'($urandom_range(0, 15));
      if (op == OP_CLOSE) op = OP_CONT;
    end else if (sel < 4) begin
      op = OP_TEXT;
    end else if (sel < 8) begin
      op = OP_BINARY;
    end else begin
      op = (sel == 8) ? OP_PING : OP_PONG;
    end
    push_byte({4'($urandom_range(0, 15)), op});
    m = 1'($urandom_range(0, 1));
    sel = $urandom_range(0, 99);
    if (sel < 60) begin
      len = 64'($urandom_range(0, 12));
      push_byte({m, len[6:0]});
    end else if (sel < 80) begin
      len = 64'($urandom_range(13, 125));
      push_byte({m, len[6:0]});
    end else if (sel < 93) begin
      len = 64'($urandom_range(0, 300));
      push_byte({m, LEN7_EXT16});
      push_byte(len[15:8]);
      push_byte(len[7:0]);
    end else begin
      len = 64'($urandom_range(0, 150));
      push_byte({m, LEN7_EXT64});
      for (int i = 7; i >= 0; i--) push_byte(len[8 * i +: 8]);
    end
    if (m) repeat (4) push_byte(8'($urandom_range(0, 255)));
    for (int i = 0; i < int'(len); i++) push_byte(8'($urandom_range(0, 255)));
  endtask

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Sender: predict on each accepted beat, hold the offer while stalled.
  always @(posedge clk_i or negedge rst_ni) begin
    deframe_res_t r;
    bit           got;
    if (!rst_ni) begin
      rx.valid   <= 1'b0;
      rx.rx_byte <= '0;
    end else begin
      if (rx.valid && rx.ready) begin
        got = deframe_byte(cur_row.b, r);
        case (cur_row.chk)
          CHK_TYPED: pending_res_q.insert(pending_res_q.size(), cur_row.res);
          CHK_MODEL: if (got) pending_res_q.insert(pending_res_q.size(), r);
          default: ;
        endcase
        rx_accepted++;
      end
      if (!rx.valid || rx.ready) begin
        if (stim_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
          cur_row = stim_q[0];
          stim_q.delete(0);
          rx.valid   <= 1'b1;
          rx.rx_byte <= cur_row.b;
        end else begin
          rx.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res.ready  <= 1'b0;
      stall_left <= 0;
      stall_done <= 1'b0;
    end else if (stall_req && !stall_done) begin
      stall_done <= 1'b1;
      stall_left <= STALL_CYCLES;
      res.ready  <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      res.ready  <= 1'b0;
    end else begin
      res.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    deframe_res_t exp_r;
    if (rst_ni && res.valid && res.ready) begin
      if (pending_res_q.size() == 0) begin
        $error("unexpected result: kind %0d byte %02h opcode %0d last %0d",
               res.kind, res.payload_byte, res.frame_opcode, res.last);
        err_cnt++;
      end else begin
        exp_r = pending_res_q[0];
        pending_res_q.delete(0);
        if (res.kind !== exp_r.kind) begin
          $error("kind: expected %0d, got %0d", exp_r.kind, res.kind);
          err_cnt++;
        end
        if (res.payload_byte !== exp_r.data) begin
          $error("payload_byte: expected %02h, got %02h", exp_r.data, res.payload_byte);
          err_cnt++;
        end
        if (res.frame_opcode !== exp_r.opcode) begin
          $error("frame_opcode: expected %0d, got %0d", exp_r.opcode, res.frame_opcode);
          err_cnt++;
        end
        if (res.last !== exp_r.last) begin
          $error("last: expected %0d, got %0d", exp_r.last, res.last);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    int rand_bytes;
    clk_i = 1'b0;
    rst_ni = 1'b0;
    rx.valid = 1'b0;
    rx.rx_byte = '0;
    res.ready = 1'b0;
    stall_req = 1'b0;
    cycles = 0;
    err_cnt = 0;
    rx_accepted = 0;
    p_phase = PS_HDR0;
    p_opcode = '0;
    p_masked = 1'b0;
    p_remaining = '0;
    p_key = '0;
    p_key_idx = '0;
    p_ext_left = '0;
    src_idle_pct = 18;
    sink_idle_pct = 46;

    for (int i = 0; i < DIRECTED_ROWS; i++) stim_q.insert(stim_q.size(), DIRECTED[i]);
    rand_bytes = stim_q.size();
    while (stim_q.size() - rand_bytes < RANDOM_BYTES)
      add_frame($urandom_range(0, 9) == 0);
    // Close last: nothing after it reaches the output.
    push_byte({4'h8, OP_CLOSE});
    if ($urandom_range(0, 1)) begin
      push_byte(8'h00);
    end else begin
      push_byte(8'h83);
      repeat (7) push_byte(8'($urandom_range(0, 255)));
    end
    repeat (4) push_byte(8'($urandom_range(0, 255)));
    rx_total = stim_q.size();

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (rx_accepted >= rx_total / 3);
    @(negedge clk_i);
    src_idle_pct = 46;
    sink_idle_pct = 18;
    wait (rx_accepted >= 2 * rx_total / 3);
    @(negedge clk_i);
    src_idle_pct = 0;
    sink_idle_pct = 0;
    stall_req = 1'b1;

    wait (rx_accepted == rx_total);
    wait (pending_res_q.size() == 0);
    repeat (10) @(posedge clk_i);
    if (pending_res_q.size() != 0) begin
      $error("%0d expected results never arrived", pending_res_q.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== websocket_frame_deframer.f =====
rtl/wsdf_pkg.sv
rtl/wsdf_rx_if.sv
rtl/wsdf_res_if.sv
rtl/websocket_frame_deframer.sv
bench/websocket_frame_deframer_tb.sv
